@@ hw/rtl/infix_to_postfix_converter_defines.svh @@
// Assertion macros for the converter's checker file.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ITP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ITP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/itp_pkg.sv @@
// Types, character constants and operator tables of the infix to postfix converter.
`default_nettype none

package itp_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       last_of_expr;
        logic       overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        CODE_ADD  = 3'd0,
        CODE_SUB  = 3'd1,
        CODE_MUL  = 3'd2,
        CODE_DIV  = 3'd3,
        CODE_MOD  = 3'd4,
        CODE_POW  = 3'd5,
        CODE_LPAR = 3'd6
    } op_code_t;

    // smaller level binds tighter; '(' never pops
    typedef logic [2:0] prec_t;

    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t code;
    } stk_cmd_t;

    typedef struct packed {
        logic     empty;
        logic     full;
        op_code_t top;
    } stk_stat_t;

    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_PCT   = 8'h25;
    localparam logic [7:0] CHR_CARET = 8'h5E;
    localparam logic [7:0] CHR_LPAR  = 8'h28;
    localparam logic [7:0] CHR_RPAR  = 8'h29;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    localparam prec_t PREC_POW  = 3'd1;
    localparam prec_t PREC_MUL  = 3'd2;
    localparam prec_t PREC_ADD  = 3'd3;
    localparam prec_t PREC_LPAR = 3'd4;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CHR_PLUS) || (c == CHR_MINUS) || (c == CHR_STAR) ||
               (c == CHR_SLASH) || (c == CHR_PCT) || (c == CHR_CARET);
    endfunction

    function automatic op_code_t char_code(input logic [7:0] c);
        op_code_t r;
        r = CODE_LPAR;
        priority if (c == CHR_PLUS)  r = CODE_ADD;
        else if (c == CHR_MINUS)     r = CODE_SUB;
        else if (c == CHR_STAR)      r = CODE_MUL;
        else if (c == CHR_SLASH)     r = CODE_DIV;
        else if (c == CHR_PCT)       r = CODE_MOD;
        else if (c == CHR_CARET)     r = CODE_POW;
        else                         r = CODE_LPAR;
        return r;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] r;
        r = CHR_NUL;
        unique case (code)
            CODE_ADD:  r = CHR_PLUS;
            CODE_SUB:  r = CHR_MINUS;
            CODE_MUL:  r = CHR_STAR;
            CODE_DIV:  r = CHR_SLASH;
            CODE_MOD:  r = CHR_PCT;
            CODE_POW:  r = CHR_CARET;
            CODE_LPAR: r = CHR_LPAR;
            default:   r = CHR_NUL;
        endcase
        return r;
    endfunction

    function automatic prec_t code_level(input op_code_t code);
        prec_t r;
        r = PREC_LPAR;
        unique case (code)
            CODE_ADD, CODE_SUB:           r = PREC_ADD;
            CODE_MUL, CODE_DIV, CODE_MOD: r = PREC_MUL;
            CODE_POW:                     r = PREC_POW;
            default:                      r = PREC_LPAR;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itp_stack.sv @@
// Operator stack: top entry in a register, the rest in a memory with a registered read.
`default_nettype none

module itp_stack
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire stk_cmd_t  cmd,
    output stk_stat_t      stat
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    op_code_t        mem [STACK_DEPTH];
    logic [CW-1:0]   count_reg, count_next;
    op_code_t        top_reg, top_next;
    op_code_t        below_reg;
    logic [CW-1:0]   wr_sum, rd_sum;
    logic [AW-1:0]   wr_idx, rd_idx;

    // below_reg always tracks entry count-2 (one under the top)
    always_comb begin
        wr_sum = count_reg - CW'(1);
        wr_idx = wr_sum[AW-1:0];
        priority if (cmd.push) begin
            rd_sum = count_reg - CW'(1);
        end else if (cmd.pop) begin
            rd_sum = count_reg - CW'(3);
        end else begin
            rd_sum = count_reg - CW'(2);
        end
        rd_idx = rd_sum[AW-1:0];
    end

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        priority if (cmd.push) begin
            count_next = count_reg + CW'(1);
            top_next   = cmd.code;
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            top_next   = below_reg;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (cmd.push && (count_reg != '0)) begin
            mem[wr_idx] <= top_reg;
        end
        // write-first: the old top lands exactly where the next read points
        below_reg <= cmd.push ? top_reg : mem[rd_idx];
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(STACK_DEPTH));
    assign stat.top   = top_reg;

endmodule

`default_nettype wire

@@ hw/rtl/itp_ctrl.sv @@
// Sequencer: classifies characters, runs pop loops on the stack, holds pending and output beats.
`default_nettype none

module itp_ctrl
    import itp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    output stk_cmd_t        stk_cmd,
    input  wire stk_stat_t  stk_stat
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EMIT   = 7'b0000010,
        ST_OPSCAN = 7'b0000100,
        ST_PUSH   = 7'b0001000,
        ST_CPSCAN = 7'b0010000,
        ST_FLUSH  = 7'b0100000,
        ST_FINAL  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] char_reg, char_next;
    logic       end_reg, end_next;
    op_code_t   code_reg, code_next;
    logic       ovf_reg, ovf_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_char_reg, pend_char_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    logic       out_free;
    logic       emit_ok;
    logic       emit_req;
    logic [7:0] emit_char;
    logic       load_out;
    out_item_t  load_data;
    logic       step_done_idle;

    assign out_free = !out_valid_reg || m_ready;
    // a new result can go to pending once the old one has room at the output
    assign emit_ok  = !pend_valid_reg || out_free;

    always_comb begin
        state_next      = state_reg;
        char_next       = char_reg;
        end_next        = end_reg;
        code_next       = code_reg;
        ovf_next        = ovf_reg;
        s_ready         = 1'b0;
        emit_req        = 1'b0;
        emit_char       = code_char(stk_stat.top);
        load_out        = 1'b0;
        load_data       = '{out_char: char_reg, has_char: 1'b1, last_of_expr: 1'b0,
                            overflow: ovf_reg};
        stk_cmd         = '{push: 1'b0, pop: 1'b0, code: code_reg};
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        step_done_idle  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    char_next = s_data.in_char;
                    end_next  = s_data.end_of_expr;
                    code_next = char_code(s_data.in_char);
                    priority if (is_space(s_data.in_char)) begin
                        state_next = s_data.end_of_expr ? ST_FLUSH : ST_IDLE;
                    end else if (is_oper(s_data.in_char)) begin
                        state_next = ST_OPSCAN;
                    end else if (s_data.in_char == CHR_LPAR) begin
                        state_next = ST_PUSH;
                    end else if (s_data.in_char == CHR_RPAR) begin
                        state_next = ST_CPSCAN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (end_reg) begin
                    emit_req   = 1'b1;
                    emit_char  = char_reg;
                    state_next = ST_FLUSH;
                end else if (out_free) begin
                    // lone operand: straight to the output register
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OPSCAN: begin
                if (!stk_stat.empty &&
                    (code_level(stk_stat.top) <= code_level(code_reg))) begin
                    if (emit_ok) begin
                        emit_req    = 1'b1;
                        stk_cmd.pop = 1'b1;
                    end
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!stk_stat.full) begin
                    stk_cmd.push = 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                step_done_idle = 1'b1;
            end
            ST_CPSCAN: begin
                if (!stk_stat.empty && (stk_stat.top != CODE_LPAR)) begin
                    if (emit_ok) begin
                        emit_req    = 1'b1;
                        stk_cmd.pop = 1'b1;
                    end
                end else begin
                    // drop the matching '(' if there is one
                    stk_cmd.pop    = !stk_stat.empty;
                    step_done_idle = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!stk_stat.empty) begin
                    if (emit_ok) begin
                        emit_req    = 1'b1;
                        stk_cmd.pop = 1'b1;
                    end
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (pend_valid_reg) begin
                        load_data = '{out_char: pend_char_reg, has_char: 1'b1,
                                      last_of_expr: end_reg, overflow: ovf_reg};
                    end else begin
                        load_data = '{out_char: CHR_NUL, has_char: 1'b0,
                                      last_of_expr: 1'b1, overflow: ovf_reg};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (step_done_idle) begin
            priority if (end_reg) begin
                state_next = ST_FLUSH;
            end else if (pend_valid_reg) begin
                state_next = ST_FINAL;
            end else begin
                state_next = ST_IDLE;
            end
        end

        // a new result retires the pending one to the output register
        if (emit_req) begin
            if (pend_valid_reg) begin
                load_out  = 1'b1;
                load_data = '{out_char: pend_char_reg, has_char: 1'b1,
                              last_of_expr: 1'b0, overflow: ovf_reg};
            end
            pend_valid_next = 1'b1;
            pend_char_next  = emit_char;
        end
    end

    always_comb begin
        out_data_next = out_data_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = load_data;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg      <= char_next;
        end_reg       <= end_next;
        code_reg      <= code_next;
        pend_char_reg <= pend_char_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/infix_to_postfix_converter.sv @@
// Top level of the shunting-yard infix to postfix converter.
//
//  Channel  Dir  Payload                                        Handshake
//  s_       in   in_char, end_of_expr                           s_valid / s_ready
//  m_       out  out_char, has_char, last_of_expr, overflow     m_valid / m_ready
//
// Whitespace is taken in IDLE, an operand goes through EMIT and '(' through PUSH;
// an operator pops in OPSCAN before its PUSH and ')' pops down to its '(' in
// CPSCAN, and both then retire the last popped beat in FINAL. An end marker
// instead flushes the stack in FLUSH, checks that it is empty and sends the last beat.
// A pop per cycle unless m_ stalls; the registered stack read sets the pop rate.
// aresetn is synchronous; the stack memory has no clearing pass after reset.
// A stalled m_ beat holds the sequencer only when another result must retire.
`default_nettype none

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    stk_cmd_t  stk_cmd;
    stk_stat_t stk_stat;

    itp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .stk_cmd  (stk_cmd),
        .stk_stat (stk_stat)
    );

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

endmodule

`default_nettype wire

@@ hw/rtl/itp_chk.sv @@
// Port-level checker for the converter, bound to the top level.
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module itp_chk
    import itp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    logic s_long_beat;
    logic m_empty;
    logic m_ovf_beat;

    // anything but plain whitespace keeps the sequencer busy for a while
    assign s_long_beat = s_valid && s_ready &&
                         (!is_space(s_data.in_char) || s_data.end_of_expr);
    assign m_empty     = m_valid && !m_data.has_char;
    assign m_ovf_beat  = m_valid && m_ready && m_data.overflow;

    `ITP_ASSERT_NEXT(a_s_busy, s_long_beat, !s_ready, "s_ready high mid-item")

    // stalled result beat holds
    `ITP_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "m_ beat changed")

    // a beat without a character is the empty end marker
    `ITP_ASSERT_NOW(a_empty_last, m_empty, m_data.last_of_expr, "empty beat not last")

    `ITP_ASSERT_NOW(a_empty_nul, m_empty, m_data.out_char == CHR_NUL, "empty beat has a char")

    // overflow is sticky across later beats
    `ITP_ASSERT_NEXT(a_ovf_sticky, m_ovf_beat, !m_valid || m_data.overflow, "overflow cleared")

endmodule

bind infix_to_postfix_converter itp_chk u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the infix to postfix converter: directed table, then random expressions.
module tb;
    import itp_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int WD_LIMIT    = 3000;
    localparam int RAND_ITEMS  = 400;
    localparam int SETTLE      = 40;

    localparam out_item_t EMPTY_END = '{out_char: CHR_NUL, has_char: 1'b0,
                                        last_of_expr: 1'b1, overflow: 1'b0};
    localparam out_item_t NO_WANT   = '0;

    typedef struct {
        logic [7:0] ch;
        bit         eoe;
        bit         typed;
        out_item_t  want;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_item_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    // predictor state
    op_code_t  op_stk [STACK_DEPTH];
    int        stk_cnt    = 0;
    int        stk_peak   = 0;
    bit        ovf_sticky = 1'b0;

    out_item_t  step_res [$];
    out_item_t  postfix_q [$];
    logic [7:0] seq_buf [$];

    int n_items   = 0;
    int n_in      = 0;
    int n_out     = 0;
    int err_cnt   = 0;
    int idle_cyc  = 0;
    int src_idle  = 0;
    int snk_stall = 0;
    out_item_t head;

    // typed rows: empty end markers and the byte extremes
    dir_row_t dir_tab [23] = '{
        '{CHR_RPAR,  1'b1, 1'b1, EMPTY_END},     // close on empty stack, end marker
        '{CHR_SPACE, 1'b1, 1'b1, EMPTY_END},
        '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{CHR_NUL,   1'b1, 1'b1, '{CHR_NUL, 1'b1, 1'b1, 1'b0}},
        '{"a",       1'b0, 1'b0, NO_WANT},
        '{CHR_PLUS,  1'b0, 1'b0, NO_WANT},
        '{"b",       1'b0, 1'b0, NO_WANT},
        '{CHR_STAR,  1'b0, 1'b0, NO_WANT},
        '{"c",       1'b0, 1'b0, NO_WANT},
        '{CHR_PCT,   1'b0, 1'b0, NO_WANT},
        '{"d",       1'b0, 1'b0, NO_WANT},
        '{CHR_CARET, 1'b0, 1'b0, NO_WANT},
        '{"e",       1'b0, 1'b0, NO_WANT},
        '{CHR_CARET, 1'b0, 1'b0, NO_WANT},     // left-assoc: pops the first ^
        '{"g",       1'b0, 1'b0, NO_WANT},
        '{CHR_SLASH, 1'b0, 1'b0, NO_WANT},
        '{CHR_LPAR,  1'b0, 1'b0, NO_WANT},
        '{"f",       1'b0, 1'b0, NO_WANT},
        '{CHR_MINUS, 1'b0, 1'b0, NO_WANT},
        '{8'h0B,     1'b0, 1'b0, NO_WANT},     // vertical tab
        '{CHR_RPAR,  1'b0, 1'b0, NO_WANT},
        '{CHR_RPAR,  1'b0, 1'b0, NO_WANT},     // unmatched: drains the stack
        '{8'h0A,     1'b1, 1'b1, EMPTY_END}
    };

    infix_to_postfix_converter u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall);
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
    endfunction

    // smaller rank binds tighter
    function automatic int bind_rank(input op_code_t c);
        case (c)
            CODE_ADD, CODE_SUB:           return 3;
            CODE_MUL, CODE_DIV, CODE_MOD: return 2;
            CODE_POW:                     return 1;
            default:                      return 4;
        endcase
    endfunction

    task automatic push_code(input op_code_t c);
        if (stk_cnt < STACK_DEPTH) begin
            op_stk[stk_cnt] = c;
            stk_cnt++;
            if (stk_cnt > stk_peak) stk_peak = stk_cnt;
        end else begin
            ovf_sticky = 1'b1;
        end
    endtask

    task automatic pop_top();
        out_item_t r;
        r = '0;
        r.has_char = 1'b1;
        case (op_stk[stk_cnt - 1])
            CODE_ADD:  r.out_char = CHR_PLUS;
            CODE_SUB:  r.out_char = CHR_MINUS;
            CODE_MUL:  r.out_char = CHR_STAR;
            CODE_DIV:  r.out_char = CHR_SLASH;
            CODE_MOD:  r.out_char = CHR_PCT;
            CODE_POW:  r.out_char = CHR_CARET;
            CODE_LPAR: r.out_char = CHR_LPAR;
            default:   r.out_char = CHR_NUL;
        endcase
        step_res = {step_res, r};
        stk_cnt--;
    endtask

    // leaves the beats caused by one character in step_res
    task automatic predict_postfix(input in_item_t it);
        op_code_t  oc;
        bit        is_op;
        int        rank;
        out_item_t r;
        step_res = {};
        oc = CODE_LPAR;
        is_op = 1'b1;
        case (it.in_char)
            CHR_PLUS:  oc = CODE_ADD;
            CHR_MINUS: oc = CODE_SUB;
            CHR_STAR:  oc = CODE_MUL;
            CHR_SLASH: oc = CODE_DIV;
            CHR_PCT:   oc = CODE_MOD;
            CHR_CARET: oc = CODE_POW;
            default:   is_op = 1'b0;
        endcase
        if (is_blank(it.in_char)) begin
            // dropped
        end else if (is_op) begin
            rank = bind_rank(oc);
            while (stk_cnt > 0 && bind_rank(op_stk[stk_cnt - 1]) <= rank) pop_top();
            push_code(oc);
        end else if (it.in_char == CHR_LPAR) begin
            push_code(CODE_LPAR);
        end else if (it.in_char == CHR_RPAR) begin
            while (stk_cnt > 0 && op_stk[stk_cnt - 1] != CODE_LPAR) pop_top();
            if (stk_cnt > 0) stk_cnt--;
        end else begin
            r = '0;
            r.out_char = it.in_char;
            r.has_char = 1'b1;
            step_res = {step_res, r};
        end
        if (it.end_of_expr) begin
            while (stk_cnt > 0) pop_top();
            if (step_res.size() == 0) begin
                r = '0;
                step_res = {step_res, r};
            end
            r = step_res.pop_back();
            r.last_of_expr = 1'b1;
            step_res = {step_res, r};
        end
        foreach (step_res[i]) begin
            r = step_res[i];
            r.overflow = ovf_sticky;
            step_res[i] = r;
        end
    endtask

    // beat monitor, result check and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) n_in++;
            if (m_valid && m_ready) begin
                n_out++;
                if (postfix_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat char %02h", m_data.out_char));
                end else begin
                    head = postfix_q.pop_front();
                    if (m_data.out_char !== head.out_char)
                        report_mismatch($sformatf("out_char got %02h want %02h",
                                                  m_data.out_char, head.out_char));
                    if (m_data.has_char !== head.has_char)
                        report_mismatch($sformatf("has_char got %b want %b",
                                                  m_data.has_char, head.has_char));
                    if (m_data.last_of_expr !== head.last_of_expr)
                        report_mismatch($sformatf("last_of_expr got %b want %b",
                                                  m_data.last_of_expr, head.last_of_expr));
                    if (m_data.overflow !== head.overflow)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  m_data.overflow, head.overflow));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= WD_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         WD_LIMIT, postfix_q.size());
                $display("** infix_to_postfix_converter: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] ch, input bit eoe, input bit typed,
                             input out_item_t want);
        in_item_t it;
        it.in_char = ch;
        it.end_of_expr = eoe;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_postfix(it);
        if (typed) postfix_q = {postfix_q, want};
        else postfix_q = {postfix_q, step_res};
        n_items++;
    endtask

    task automatic send_char(input logic [7:0] ch, input bit eoe);
        send_item(ch, eoe, 1'b0, NO_WANT);
    endtask

    // end marker rides on the last character
    task automatic send_seq();
        foreach (seq_buf[i]) send_char(seq_buf[i], i == seq_buf.size() - 1);
        seq_buf = {};
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (postfix_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_oper();
        case ($urandom_range(5))
            0:       return CHR_PLUS;
            1:       return CHR_MINUS;
            2:       return CHR_STAR;
            3:       return CHR_SLASH;
            4:       return CHR_PCT;
            default: return CHR_CARET;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CHR_SPACE : CHR_TAB + k[7:0];
    endfunction

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(5))
            0, 1:    return 8'($urandom_range(8'h61, 8'h7A));
            2:       return 8'($urandom_range(8'h30, 8'h39));
            3:       return 8'($urandom_range(8'h41, 8'h5A));
            4:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(8'h0E, 8'h1F));
        endcase
    endfunction

    // well-formed expression, broken now and then
    task automatic gen_expr();
        int n_terms;
        int open;
        int k;
        n_terms = $urandom_range(1, 6);
        open = 0;
        for (int t = 0; t < n_terms; t++) begin
            if (t > 0) seq_buf = {seq_buf, rand_oper()};
            while (open < 5 && $urandom_range(3) == 0) begin
                seq_buf = {seq_buf, CHR_LPAR};
                open++;
            end
            seq_buf = {seq_buf, rand_operand()};
            while (open > 0 && $urandom_range(2) == 0) begin
                seq_buf = {seq_buf, CHR_RPAR};
                open--;
            end
            if ($urandom_range(9) == 0) seq_buf = {seq_buf, rand_blank()};
        end
        while (open > 0) begin
            seq_buf = {seq_buf, CHR_RPAR};
            open--;
        end
        if ($urandom_range(4) == 0) begin
            k = $urandom_range(seq_buf.size() - 1);
            case ($urandom_range(2))
                0:       seq_buf.delete(k);
                1:       seq_buf.insert(k, CHR_RPAR);
                default: seq_buf.insert(k, rand_oper());
            endcase
        end
        send_seq();
    endtask

    task automatic gen_noise();
        int n;
        logic [7:0] c;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0) begin
                c = 8'($urandom_range(255));
            end else begin
                case ($urandom_range(3))
                    0:       c = rand_oper();
                    1:       c = CHR_LPAR;
                    2:       c = CHR_RPAR;
                    default: c = rand_blank();
                endcase
            end
            send_char(c, (i == n - 1) || ($urandom_range(9) == 0));
        end
    endtask

    // deep nesting up to a full stack; unclosed half the time so the flush is long
    task automatic gen_deep();
        int k;
        k = $urandom_range(8, STACK_DEPTH - 1);
        repeat (k) seq_buf = {seq_buf, CHR_LPAR};
        seq_buf = {seq_buf, rand_operand()};
        seq_buf = {seq_buf, rand_oper()};
        seq_buf = {seq_buf, rand_operand()};
        if ($urandom_range(1) == 0) begin
            repeat (k) seq_buf = {seq_buf, CHR_RPAR};
        end
        send_seq();
    endtask

    initial begin
        int goal;
        int pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].ch, dir_tab[i].eoe, dir_tab[i].typed, dir_tab[i].want);
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle = 0;
                    snk_stall = 0;
                end
                1: begin
                    src_idle = 82;
                    snk_stall = 0;
                end
                2: begin
                    src_idle = 0;
                    snk_stall = 82;
                end
                default: begin
                    src_idle = 11;
                    snk_stall = 11;
                end
            endcase
            if (ph == 3) begin
                // one push past a full stack: overflow sticks from here on
                repeat (STACK_DEPTH + 1) seq_buf = {seq_buf, CHR_LPAR};
                seq_buf = {seq_buf, rand_operand()};
                send_seq();
            end
            goal = n_items + RAND_ITEMS / 4;
            while (n_items < goal) begin
                pick = $urandom_range(99);
                if (pick < 65) gen_expr();
                else if (pick < 85) gen_noise();
                else gen_deep();
            end
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        if (postfix_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", postfix_q.size()));

        $display("Covered %0d characters in, %0d postfix beats out, deepest stack %0d,",
                 n_in, n_out, stk_peak);
        $display("  four idle/stall mixes, overflow flag %s", ovf_sticky ? "raised" : "never raised");
        if (err_cnt == 0) begin
            $display("** infix_to_postfix_converter: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter: FAILED **");
        end
        $finish;
    end

endmodule

@@ infix_to_postfix_converter.f @@
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_stack.sv
hw/rtl/itp_ctrl.sv
hw/rtl/infix_to_postfix_converter.sv
hw/rtl/itp_chk.sv
bench/tb.sv
